### design/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W   = 8;
  localparam int ID_W     = 16;
  localparam int AGE_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // request kind
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // update the sorted row and load the result register
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage
`default_nettype wire

### design/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes a request, issues one execute step, owns result valid.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output spq_pkg::cmd_t     cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic            out_valid_next;
  logic            slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (in_valid) state_next = spq_pkg::ST_EXEC;
      end
      spq_pkg::ST_EXEC: begin
        if (slot_free) state_next = spq_pkg::ST_IDLE;
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      spq_pkg::ST_EXEC: begin
        cmd.execute = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### design/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted register row with per-cell compare and shift, plus result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire spq_pkg::cmd_t                      cmd,
  input  wire logic                               req_op,
  input  wire logic [spq_pkg::PRIO_W-1:0]         req_prio,
  input  wire logic [spq_pkg::ID_W-1:0]           req_id,
  input  wire logic [spq_pkg::AGE_W-1:0]          req_age,
  output logic      [spq_pkg::STATUS_W-1:0]       res_status,
  output logic      [spq_pkg::ID_W-1:0]           res_id,
  output logic      [spq_pkg::AGE_W-1:0]          res_age,
  output logic      [spq_pkg::COUNT_W-1:0]        res_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic            op;
  spq_pkg::entry_t req;

  spq_pkg::entry_t entries      [DEPTH];
  spq_pkg::entry_t entries_next [DEPTH];
  logic [DEPTH-1:0] keep;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [spq_pkg::STATUS_W-1:0] status_next;
  logic            is_full;
  logic            is_empty;

  assign is_full  = (count == FULL_COUNT);
  assign is_empty = (count == '0);

  // cells ahead of the insert point: occupied and not lower priority.
  // The row is sorted, so this is a prefix.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CW'(i) < count) && (entries[i].prio >= req.prio);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (op == spq_pkg::OP_INSERT) begin
        if (!is_full && !keep[i]) begin
          if (i == 0) begin
            entries_next[i] = req;
          end else if (keep[i-1]) begin
            entries_next[i] = req;
          end else begin
            entries_next[i] = entries[i-1];
          end
        end
      end else if (!is_empty && i < DEPTH - 1) begin
        entries_next[i] = entries[i+1];
      end
    end
  end

  always_comb begin
    count_next  = count;
    status_next = spq_pkg::STATUS_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (is_full) begin
        status_next = spq_pkg::STATUS_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = spq_pkg::STATUS_EMPTY;
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= req_op;
      req.prio <= req_prio;
      req.id   <= req_id;
      req.age  <= req_age;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  // result register; count is reported modulo 32
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_status <= status_next;
      res_count  <= spq_pkg::COUNT_W'(count_next);
      if (op == spq_pkg::OP_POP && !is_empty) begin
        res_id  <= entries[0].id;
        res_age <= entries[0].age;
      end else begin
        res_id  <= '0;
        res_age <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### design/stable_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue with first-in, first-out order among equal priorities.
// ----------------------------------------------------------------------------
// Each request on s_axis is an insert or a pop and yields exactly one result
// on m_axis. A request is captured in ST_IDLE; in ST_EXEC every cell of the
// sorted register row compares its priority and shifts in parallel. No new
// request is taken until the last one has executed, and ST_EXEC waits while
// a pending result is not taken. A finished result waits in an output register
// while the next request is accepted. Entries are held in DEPTH flip-flop cells;
// reset only clears the entry count, so the block is ready right after reset. An
// insert into a full queue is dropped and flagged; an empty pop is flagged.
module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // priority_req[7:0], patient_id[23:8], age[31:24]
  input  wire logic [0:0]  s_axis_tuser,  // operation[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // removed_id[15:0], removed_age[23:16],
                                          // entry_count[28:24], zeros[31:29]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  spq_pkg::cmd_t cmd;
  logic [spq_pkg::STATUS_W-1:0] res_status;
  logic [spq_pkg::ID_W-1:0]     res_id;
  logic [spq_pkg::AGE_W-1:0]    res_age;
  logic [spq_pkg::COUNT_W-1:0]  res_count;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_op     (s_axis_tuser[0]),
    .req_prio   (s_axis_tdata[7:0]),
    .req_id     (s_axis_tdata[23:8]),
    .req_age    (s_axis_tdata[31:24]),
    .res_status (res_status),
    .res_id     (res_id),
    .res_age    (res_age),
    .res_count  (res_count)
  );

  assign m_axis_tdata = {3'b000, res_count, res_age, res_id};
  assign m_axis_tuser = res_status;

  // one request in flight: no accept in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one executes");

  // a rejected insert only happens with the queue at capacity
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == spq_pkg::STATUS_FULL)
      |-> (m_axis_tdata[28:24] == spq_pkg::COUNT_W'(DEPTH)))
    else $error("full status with count below capacity");

  // an empty pop reports an empty queue and no payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == spq_pkg::STATUS_EMPTY)
      |-> (m_axis_tdata[28:0] == '0))
    else $error("empty status with nonzero payload or count");

  // count never exceeds capacity (checked where the field can show it)
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (DEPTH > 31) || (32'(m_axis_tdata[28:24]) <= 32'(DEPTH)))
    else $error("entry count above capacity");

endmodule
`default_nettype wire

### tb/sv/tb_stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the bounded stable priority queue.
// ----------------------------------------------------------------------------
// Requests go in on s_axis and are taken from a pending queue by a clocked
// driver. A behavioral sorted list tracks the queue contents. For every
// accepted request it computes the status, popped id and age, and entry count
// that the block must return. A clocked monitor checks each result on m_axis
// against the oldest open prediction. The stimulus starts with a short
// directed sequence and then moves on to random runs. These runs lean toward
// filling the queue or toward draining it, with both wide and narrow
// priority spreads. Random idle bursts on either side come in some phases
// and are left out in others.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic                       op;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::ID_W-1:0]   id;
    logic [spq_pkg::AGE_W-1:0]  age;
    int unsigned                gap_after;
  } request_t;

  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::ID_W-1:0]     id;
    logic [spq_pkg::AGE_W-1:0]    age;
    logic [spq_pkg::COUNT_W-1:0]  count;
    logic [2:0]                   pad;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // priority_req[7:0], patient_id[23:8], age[31:24]
  logic [0:0]  s_axis_tuser = '0;   // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // removed_id[15:0], removed_age[23:16],
                                    // entry_count[28:24], zeros[31:29]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  request_t        pending_reqs[$];
  result_t         expected_results[$];
  spq_pkg::entry_t sorted_entries[$];

  request_t    next_req;
  result_t     got_result;
  result_t     want_result;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  bit          sink_bursty = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned n_insert = 0;
  int unsigned n_pop = 0;
  int unsigned n_full = 0;
  int unsigned n_empty = 0;
  int unsigned peak_count = 0;

  stable_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Sorted list update: new entries go behind all of equal or higher priority.
  function automatic result_t apply_request(logic op,
                                            logic [spq_pkg::PRIO_W-1:0] prio,
                                            logic [spq_pkg::ID_W-1:0] id,
                                            logic [spq_pkg::AGE_W-1:0] age);
    result_t         r;
    spq_pkg::entry_t e;
    int              pos;
    r = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (sorted_entries.size() >= QUEUE_DEPTH) begin
        r.status = spq_pkg::STATUS_FULL;
      end else begin
        pos = sorted_entries.size();
        for (int i = 0; i < sorted_entries.size(); i++) begin
          if (sorted_entries[i].prio < prio) begin
            pos = i;
            break;
          end
        end
        e.prio = prio;
        e.id   = id;
        e.age  = age;
        sorted_entries.insert(pos, e);
        r.status = spq_pkg::STATUS_OK;
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        e = sorted_entries.pop_front();
        r.status = spq_pkg::STATUS_OK;
        r.id     = e.id;
        r.age    = e.age;
      end
    end
    r.count = spq_pkg::COUNT_W'(sorted_entries.size());
    return r;
  endfunction

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"[%0t] %s: expected status=%0d id=%h age=%h count=%0d pad=%0d,",
                " got status=%0d id=%h age=%h count=%0d pad=%0d"},
               $time, what, want.status, want.id, want.age, want.count, want.pad,
               got.status, got.id, got.age, got.count, got.pad);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap--;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_req.op;
        s_axis_tdata  <= {next_req.age, next_req.id, next_req.prio};
        src_gap = next_req.gap_after;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_bursty && $urandom_range(0, 7) == 0)
        sink_hold = $urandom_range(1, 15);
    end
  end

  // Check results first, then predict for the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_result.status = m_axis_tuser;
        got_result.id     = m_axis_tdata[15:0];
        got_result.age    = m_axis_tdata[23:16];
        got_result.count  = m_axis_tdata[28:24];
        got_result.pad    = m_axis_tdata[31:29];
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got_result);
        end else begin
          want_result = expected_results.pop_front();
          if (got_result !== want_result)
            note_mismatch("result mismatch", want_result, got_result);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want_result = apply_request(s_axis_tuser[0], s_axis_tdata[7:0],
                                    s_axis_tdata[23:8], s_axis_tdata[31:24]);
        expected_results.push_back(want_result);
        if (s_axis_tuser[0] == spq_pkg::OP_INSERT) n_insert++;
        else n_pop++;
        if (want_result.status == spq_pkg::STATUS_FULL) n_full++;
        if (want_result.status == spq_pkg::STATUS_EMPTY) n_empty++;
        if (want_result.count > peak_count) peak_count = want_result.count;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still open", cycle_count,
               expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_req(logic op, logic [spq_pkg::PRIO_W-1:0] prio,
                          logic [spq_pkg::ID_W-1:0] id,
                          logic [spq_pkg::AGE_W-1:0] age, int unsigned gap);
    request_t r;
    r.op        = op;
    r.prio      = prio;
    r.id        = id;
    r.age       = age;
    r.gap_after = gap;
    pending_reqs.push_back(r);
  endtask

  // Runs lean toward filling or draining so that full and empty both show up.
  task automatic add_random_runs(int unsigned n, bit bursty);
    int unsigned added;
    int unsigned run_len;
    int unsigned insert_pct;
    int unsigned prio_style;
    logic        op;
    logic [7:0]  prio;
    added = 0;
    while (added < n) begin
      run_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 25;
        default: insert_pct = 55;
      endcase
      prio_style = $urandom_range(0, 2);
      for (int k = 0; k < run_len && added < n; k++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
        case (prio_style)
          0: prio = 8'($urandom_range(0, 255));
          1: begin
            case ($urandom_range(0, 3))
              0: prio = 8'h00;
              1: prio = 8'hFF;
              2: prio = 8'h80;
              default: prio = 8'($urandom_range(0, 255));
            endcase
          end
          default: prio = 8'($urandom_range(0, 3));
        endcase
        push_req(op, prio, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 (bursty && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0);
        added++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
      @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pop, field extremes, ties in FIFO order, drain to empty
    push_req(spq_pkg::OP_POP,    8'h00, 16'h0000, 8'h00, 0);
    push_req(spq_pkg::OP_INSERT, 8'h00, 16'h0000, 8'h00, 0);
    push_req(spq_pkg::OP_INSERT, 8'hFF, 16'hFFFF, 8'hFF, 0);
    push_req(spq_pkg::OP_INSERT, 8'h80, 16'h1111, 8'h11, 0);
    push_req(spq_pkg::OP_INSERT, 8'h80, 16'h2222, 8'h22, 0);
    push_req(spq_pkg::OP_INSERT, 8'h80, 16'h3333, 8'h33, 0);
    push_req(spq_pkg::OP_INSERT, 8'h7F, 16'hA5A5, 8'h5A, 0);
    push_req(spq_pkg::OP_INSERT, 8'h81, 16'h5A5A, 8'hA5, 0);
    push_req(spq_pkg::OP_INSERT, 8'hFF, 16'hFFFE, 8'hFE, 0);
    for (int i = 0; i < 9; i++)
      push_req(spq_pkg::OP_POP, 8'hFF, 16'hFFFF, 8'hFF, 0);
    wait_idle();

    // random phases; bursts in phases 0 and 2, phases 1 and 3 run flat out
    for (int phase = 0; phase < 4; phase++) begin
      sink_bursty = (phase % 2 == 0);
      add_random_runs(200, phase % 2 == 0);
      wait_idle();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts and %0d pops, %0d full rejects, %0d empty pops",
             n_insert, n_pop, n_full, n_empty);
    $display("queue occupancy peaked at %0d entries, %0d mismatches", peak_count, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
